// ===== src/assert_macros.svh =====
// assertion helpers shared by the controller and datapath files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ===== src/hasb_pkg.sv =====
`timescale 1ns / 1ps

package hasb_pkg;

    localparam int MAX_ENTRIES = 512;
    localparam int VEC_WIDTH   = 32;

    localparam int ADDR_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);

    // fixed field widths of the ports
    localparam int ACT_W    = 2;
    localparam int VEC_IN_W = 32;
    localparam int IDX_W    = 9;
    localparam int STAT_W   = 3;
    localparam int SIZE_W   = 10;
    localparam int TGT_W    = 10;

    // common width for count / index / target compares
    localparam int CMP_W = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;

    typedef enum logic [ACT_W-1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_SEED   = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_TRY    = 2'd3
    } action_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_DONE   = 3'd0,
        STAT_DUP    = 3'd1,
        STAT_RIGHT  = 3'd2,
        STAT_FULL   = 3'd3,
        STAT_BADIDX = 3'd4
    } status_code_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_RM_WR,
        S_DUP_SCAN,
        S_DUP_DRAIN,
        S_LOAD_A,
        S_PAIR_SCAN,
        S_PAIR_DRAIN
    } state_t;

    typedef struct packed {
        logic [ACT_W-1:0]    action;
        logic [VEC_IN_W-1:0] vector;
        logic [IDX_W-1:0]    index;
    } in_item_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [SIZE_W-1:0] set_size;
    } out_item_t;

    // controller -> datapath
    typedef struct packed {
        logic         load;
        logic         clr_count;
        logic         append;
        logic         rd_last;
        logic         rm_write;
        logic         dup_start;
        logic         scan_dup;
        logic         pair_start;
        logic         load_a;
        logic         inc_i;
        logic         scan_pair;
        logic         finish;
        status_code_t fin_status;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        action_t action;
        logic    full_max;
        logic    full_try;
        logic    bad_idx;
        logic    cnt_lt2;
        logic    j_end;
        logic    i_last;
        logic    dup_hit;
        logic    ra_hit;
    } dp_stat_t;

endpackage

// ===== src/hasb_ctrl.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hasb_ctrl
    import hasb_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd,
    output logic     busy
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                unique case (stat.action)
                    ACT_REMOVE:
                    begin
                        state_next = stat.bad_idx ? S_IDLE : S_RM_WR;
                    end
                    ACT_TRY:
                    begin
                        state_next = stat.full_try ? S_IDLE : S_DUP_SCAN;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_RM_WR:
            begin
                state_next = S_IDLE;
            end
            S_DUP_SCAN:
            begin
                if (stat.j_end)
                begin
                    state_next = S_DUP_DRAIN;
                end
            end
            S_DUP_DRAIN:
            begin
                if (stat.dup_hit || stat.cnt_lt2)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_LOAD_A;
                end
            end
            S_LOAD_A:
            begin
                state_next = S_PAIR_SCAN;
            end
            S_PAIR_SCAN:
            begin
                if (stat.j_end)
                begin
                    state_next = S_PAIR_DRAIN;
                end
            end
            S_PAIR_DRAIN:
            begin
                if (stat.ra_hit || stat.i_last)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_LOAD_A;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // commands
    always_comb
    begin
        cmd            = '0;
        cmd.fin_status = STAT_DONE;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load = start;
            end
            S_EXEC:
            begin
                unique case (stat.action)
                    ACT_CLEAR:
                    begin
                        cmd.clr_count = 1'b1;
                        cmd.finish    = 1'b1;
                    end
                    ACT_SEED:
                    begin
                        cmd.finish = 1'b1;
                        if (stat.full_max)
                        begin
                            cmd.fin_status = STAT_FULL;
                        end
                        else
                        begin
                            cmd.append = 1'b1;
                        end
                    end
                    ACT_REMOVE:
                    begin
                        if (stat.bad_idx)
                        begin
                            cmd.finish     = 1'b1;
                            cmd.fin_status = STAT_BADIDX;
                        end
                        else
                        begin
                            cmd.rd_last = 1'b1;
                        end
                    end
                    ACT_TRY:
                    begin
                        if (stat.full_try)
                        begin
                            cmd.finish     = 1'b1;
                            cmd.fin_status = STAT_FULL;
                        end
                        else
                        begin
                            cmd.dup_start = 1'b1;
                        end
                    end
                    default:
                    begin
                        cmd.finish = 1'b1;
                    end
                endcase
            end
            S_RM_WR:
            begin
                cmd.rm_write = 1'b1;
                cmd.finish   = 1'b1;
            end
            S_DUP_SCAN:
            begin
                cmd.scan_dup = !stat.j_end;
            end
            S_DUP_DRAIN:
            begin
                if (stat.dup_hit)
                begin
                    cmd.finish     = 1'b1;
                    cmd.fin_status = STAT_DUP;
                end
                else if (stat.cnt_lt2)
                begin
                    cmd.append = 1'b1;
                    cmd.finish = 1'b1;
                end
                else
                begin
                    cmd.pair_start = 1'b1;
                end
            end
            S_LOAD_A:
            begin
                cmd.load_a = 1'b1;
            end
            S_PAIR_SCAN:
            begin
                cmd.scan_pair = !stat.j_end;
            end
            S_PAIR_DRAIN:
            begin
                if (stat.ra_hit)
                begin
                    cmd.finish     = 1'b1;
                    cmd.fin_status = STAT_RIGHT;
                end
                else if (stat.i_last)
                begin
                    cmd.append = 1'b1;
                    cmd.finish = 1'b1;
                end
                else
                begin
                    cmd.inc_i = 1'b1;
                end
            end
            default:
            begin
                cmd.finish = 1'b1;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    `ASSERT_CLK(a_fin_to_idle, cmd.finish |=> state_reg == S_IDLE, "finish not followed by idle")
    `ASSERT_CLK(a_pair_needs_two, (state_reg == S_PAIR_SCAN) |-> !stat.cnt_lt2,
                "pair scan with fewer than two entries")
    `ASSERT_NEVER(a_append_full, cmd.append && stat.full_max, "append into full store")

endmodule

// ===== src/hasb_dp.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hasb_dp
    import hasb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  in_item_t         request,
    input  logic [TGT_W-1:0] cfg_data,
    input  logic             cfg_wr,
    input  dp_cmd_t          cmd,
    output dp_stat_t         stat,
    output logic             done,
    output out_item_t        result
);

    logic [VEC_WIDTH-1:0] mem [MAX_ENTRIES];

    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic [TGT_W-1:0]     target_reg;
    logic                 done_reg;
    status_code_t         status_reg;
    action_t              action_reg;
    logic [VEC_WIDTH-1:0] cand_reg;
    logic [IDX_W-1:0]     index_reg;
    logic [CNT_W-1:0]     i_reg;
    logic [CNT_W-1:0]     j_reg;
    logic [VEC_WIDTH-1:0] rd_a_reg;
    logic [VEC_WIDTH-1:0] rd_b_reg;
    logic                 pend_dup_reg;
    logic                 pend_pair_reg;
    logic                 dup_hit_reg;
    logic                 dup_hit_next;
    logic                 ra_hit_reg;
    logic                 ra_hit_next;

    logic [CNT_W-1:0]     last_idx;
    logic [CNT_W-1:0]     b_idx;
    logic [CMP_W-1:0]     idx_ext;
    logic [CMP_W-1:0]     cnt_ext;
    logic [CMP_W-1:0]     size_ext;
    logic [CNT_W:0]       i_plus2;
    logic [VEC_WIDTH-1:0] dx_a;
    logic [VEC_WIDTH-1:0] dx_b;
    logic [VEC_WIDTH-1:0] d_ab;
    logic                 pair_hit;

    assign last_idx = count_reg - CNT_W'(1);
    assign b_idx    = cmd.rd_last ? last_idx : j_reg;
    assign idx_ext  = CMP_W'(index_reg);
    assign cnt_ext  = CMP_W'(count_reg);
    assign i_plus2  = {1'b0, i_reg} + (CNT_W + 1)'(2);

    // three apexes of one unordered pair {a, b} with the candidate
    assign dx_a     = rd_a_reg ^ cand_reg;
    assign dx_b     = rd_b_reg ^ cand_reg;
    assign d_ab     = rd_a_reg ^ rd_b_reg;
    assign pair_hit = ((dx_a & dx_b) == '0) || ((dx_a & d_ab) == '0)
                   || ((dx_b & d_ab) == '0);

    always_comb
    begin
        count_next = count_reg;
        if (cmd.clr_count)
        begin
            count_next = '0;
        end
        else if (cmd.append)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.rm_write)
        begin
            count_next = last_idx;
        end
    end

    always_comb
    begin
        dup_hit_next = dup_hit_reg;
        ra_hit_next  = ra_hit_reg;
        if (cmd.dup_start)
        begin
            dup_hit_next = 1'b0;
            ra_hit_next  = 1'b0;
        end
        else
        begin
            if (pend_dup_reg && (rd_b_reg == cand_reg))
            begin
                dup_hit_next = 1'b1;
            end
            if (pend_pair_reg && pair_hit)
            begin
                ra_hit_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            target_reg    <= TGT_W'(512);
            done_reg      <= 1'b0;
            pend_dup_reg  <= 1'b0;
            pend_pair_reg <= 1'b0;
            dup_hit_reg   <= 1'b0;
            ra_hit_reg    <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            done_reg      <= cmd.finish;
            pend_dup_reg  <= cmd.scan_dup;
            pend_pair_reg <= cmd.scan_pair;
            dup_hit_reg   <= dup_hit_next;
            ra_hit_reg    <= ra_hit_next;
            if (cfg_wr)
            begin
                target_reg <= cfg_data;
            end
        end
    end

    // item fields, scan counters, result code
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            action_reg <= action_t'(request.action);
            cand_reg   <= request.vector[VEC_WIDTH-1:0];
            index_reg  <= request.index;
        end
        if (cmd.dup_start)
        begin
            j_reg <= '0;
        end
        else if (cmd.load_a)
        begin
            j_reg <= i_reg + CNT_W'(1);
        end
        else if (cmd.scan_dup || cmd.scan_pair)
        begin
            j_reg <= j_reg + CNT_W'(1);
        end
        if (cmd.pair_start)
        begin
            i_reg <= '0;
        end
        else if (cmd.inc_i)
        begin
            i_reg <= i_reg + CNT_W'(1);
        end
        if (cmd.finish)
        begin
            status_reg <= cmd.fin_status;
        end
    end

    // set store: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (cmd.append)
        begin
            mem[count_reg[ADDR_W-1:0]] <= cand_reg;
        end
        else if (cmd.rm_write)
        begin
            mem[idx_ext[ADDR_W-1:0]] <= rd_b_reg;
        end
        rd_a_reg <= mem[i_reg[ADDR_W-1:0]];
        rd_b_reg <= mem[b_idx[ADDR_W-1:0]];
    end

    assign stat.action   = action_reg;
    assign stat.full_max = (count_reg == CNT_W'(MAX_ENTRIES));
    assign stat.full_try = (cnt_ext >= CMP_W'(target_reg)) || stat.full_max;
    assign stat.bad_idx  = (idx_ext >= cnt_ext);
    assign stat.cnt_lt2  = (count_reg < CNT_W'(2));
    assign stat.j_end    = (j_reg >= count_reg);
    assign stat.i_last   = (i_plus2 >= {1'b0, count_reg});
    assign stat.dup_hit  = dup_hit_reg;
    assign stat.ra_hit   = ra_hit_reg;

    assign size_ext        = CMP_W'(count_reg);
    assign done            = done_reg;
    assign result.status   = status_reg;
    assign result.set_size = size_ext[SIZE_W-1:0];

    `ASSERT_NEVER(a_count_range, count_reg > CNT_W'(MAX_ENTRIES), "entry count past store depth")
    `ASSERT_CLK(a_count_moves_on_finish, !cmd.finish |=> $stable(count_reg),
                "entry count changed outside a finishing beat")
    `ASSERT_CLK(a_apex_row_stable, cmd.scan_pair |=> $stable(rd_a_reg),
                "outer entry moved during pair scan")

endmodule

// ===== src/hypercube_acute_set_builder_unit.sv =====
`timescale 1ns / 1ps

// Acute set builder over 0/1 hypercube vertices. A command beat is taken at a
// clock edge with start high and busy low; its single result (status and the
// entry count after the action) is shown for exactly one cycle with done high,
// and the receiver cannot stall it. busy is already low in that done cycle, so
// the next command may be taken there. A try-add over m stored entries first
// runs a duplicate scan over all m entries, then, for m of two or more, a pair
// scan that takes each unordered pair of entries once, one pair per cycle
// through the two read ports of the set store; a duplicate or a right angle
// ends the try-add early. No clearing pass is needed after reset; only entries
// below the count are ever used. target_size is written on the cfg channel,
// which is always ready; write it only while no command is in flight.

module hypercube_acute_set_builder_unit
    import hasb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    // command channel
    input  logic             start,
    output logic             busy,
    input  in_item_t         request,
    // result channel
    output logic             done,
    output out_item_t        result,
    // target_size write channel
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [TGT_W-1:0] cfg_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     ctrl_busy;

    // register takes every write as it is offered, so the channel never back-pressures
    assign cfg_ready = 1'b1;
    assign busy      = ctrl_busy;

    // sequencer: decodes the action and steps the scans
    hasb_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (ctrl_busy)
    );

    // set store, count, scan counters and the pair compare
    hasb_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request),
        .cfg_data (cfg_data),
        .cfg_wr   (cfg_valid),
        .cmd      (cmd),
        .stat     (stat),
        .done     (done),
        .result   (result)
    );

endmodule

// ===== dv/tb_hypercube_acute_set_builder_unit.sv =====
`timescale 1ns / 1ps

module tb_hypercube_acute_set_builder_unit;
    import hasb_pkg::*;

    // cycles with no beat at all before the run is called hung; the slowest
    // command here is a try-add over about 40 entries
    localparam int STALL_LIMIT = 20000;
    // random stimulus stops growing the set once it is past this, to keep scans short
    localparam int GROW_CAP = 40;
    localparam logic [VEC_IN_W-1:0] VEC_KEEP = 32'hFFFF_FFFF >> (32 - VEC_WIDTH);

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    in_item_t          request = '0;
    logic              done;
    out_item_t         result;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [TGT_W-1:0]  cfg_data = '0;

    hypercube_acute_set_builder_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // shadow of the vertex set, entry count and target size
    logic [VEC_IN_W-1:0] acute_set [MAX_ENTRIES];
    int                  member_count = 0;
    logic [TGT_W-1:0]    size_limit = 10'd512;

    in_item_t  pending_cmds [$];
    out_item_t expected_outcomes [$];
    int        accept_count = 0;
    int        drive_count = 0;
    int        gap_left = 0;
    int        stall_cycles = 0;
    bit        mismatch_seen = 1'b0;

    // ------------------------------------------------------------------
    // set model
    // ------------------------------------------------------------------

    function automatic bit vector_in_set(logic [VEC_IN_W-1:0] v);
        int i;
        for (i = 0; i < member_count; i++)
            if (acute_set[i] == v)
                return 1'b1;
        return 1'b0;
    endfunction

    // right angle with the candidate as apex, or with a member as apex and
    // the candidate as one arm; equal members count as a right angle
    function automatic bit angle_found(logic [VEC_IN_W-1:0] v);
        int a;
        int b;
        int q;
        logic [VEC_IN_W-1:0] arm;
        for (a = 0; a < member_count; a++)
        begin
            arm = acute_set[a] ^ v;
            for (b = a + 1; b < member_count; b++)
                if ((arm & (acute_set[b] ^ v)) == '0)
                    return 1'b1;
        end
        for (q = 0; q < member_count; q++)
        begin
            arm = v ^ acute_set[q];
            for (a = 0; a < member_count; a++)
                if (a != q && (arm & (acute_set[a] ^ acute_set[q])) == '0)
                    return 1'b1;
        end
        return 1'b0;
    endfunction

    // applies one command to the shadow set and returns its outcome
    function automatic out_item_t acute_set_outcome(in_item_t cmd);
        out_item_t    res;
        status_code_t st;
        logic [VEC_IN_W-1:0] v;
        v  = cmd.vector & VEC_KEEP;
        st = STAT_DONE;
        case (cmd.action)
            ACT_CLEAR:
                member_count = 0;
            ACT_SEED:
                if (member_count >= MAX_ENTRIES)
                    st = STAT_FULL;
                else
                begin
                    acute_set[member_count] = v;
                    member_count++;
                end
            ACT_REMOVE:
                if (cmd.index >= member_count)
                    st = STAT_BADIDX;
                else
                begin
                    // last entry moves into the freed slot
                    member_count--;
                    acute_set[cmd.index] = acute_set[member_count];
                end
            default:
                // full beats duplicate beats right angle
                if (member_count >= size_limit || member_count >= MAX_ENTRIES)
                    st = STAT_FULL;
                else if (vector_in_set(v))
                    st = STAT_DUP;
                else if (angle_found(v))
                    st = STAT_RIGHT;
                else
                begin
                    acute_set[member_count] = v;
                    member_count++;
                end
        endcase
        res.status   = st;
        res.set_size = SIZE_W'(member_count);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // command side
    // ------------------------------------------------------------------

    // mostly back-to-back or short gaps, now and then a long one
    function automatic int idle_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            return 0;
        else if (pick < 85)
            return $urandom_range(1, 3);
        else if (pick < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // command beat taken and cfg writes land in the shadow state here
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                size_limit = cfg_data;
            if (start && !busy)
            begin
                expected_outcomes.push_back(acute_set_outcome(request));
                void'(pending_cmds.pop_front());
                accept_count++;
            end
        end
    end

    // driver: holds start until the beat is taken, then gaps or moves on
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            start    <= 1'b0;
            request  <= '0;
            gap_left <= 0;
        end
        else if (!(start && accept_count < drive_count))
        begin
            if (gap_left > 0)
            begin
                start    <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_cmds.size() != 0)
            begin
                start    <= 1'b1;
                request  <= pending_cmds[0];
                gap_left <= idle_gap();
                drive_count++;
            end
            else
                start <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_outcomes.size() == 0)
            begin
                $error("result beat with no command outstanding: status %0d size %0d",
                       result.status, result.set_size);
                mismatch_seen = 1'b1;
            end
            else
            begin
                if (result.status !== expected_outcomes[0].status)
                begin
                    $error("status: expected %0d, got %0d",
                           expected_outcomes[0].status, result.status);
                    mismatch_seen = 1'b1;
                end
                if (result.set_size !== expected_outcomes[0].set_size)
                begin
                    $error("set_size: expected %0d, got %0d",
                           expected_outcomes[0].set_size, result.set_size);
                    mismatch_seen = 1'b1;
                end
                void'(expected_outcomes.pop_front());
            end
        end
    end

    // watchdog on cycles without any beat on any channel
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("[hypercube_acute_set_builder_unit] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    // one command in flight from the generator's view, so that random
    // choices see the set as the block holds it
    task automatic wait_slot();
        while (pending_cmds.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_cmd(action_t act, logic [VEC_IN_W-1:0] v, logic [IDX_W-1:0] idx);
        in_item_t c;
        wait_slot();
        c.action = act;
        c.vector = v;
        c.index  = idx;
        pending_cmds.push_back(c);
    endtask

    // target size only changes with nothing in flight
    task automatic write_target(logic [TGT_W-1:0] value);
        while (pending_cmds.size() != 0 || expected_outcomes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [VEC_IN_W-1:0] any_member();
        return acute_set[$urandom_range(0, member_count - 1)];
    endfunction

    // mostly try-adds built to hit duplicates and right angles, with clears,
    // seeds and removes mixed in
    task automatic send_random_cmd();
        int pick;
        int kind;
        logic [VEC_IN_W-1:0] v;
        logic [VEC_IN_W-1:0] p;
        logic [VEC_IN_W-1:0] r;
        logic [IDX_W-1:0] idx;
        action_t act;
        in_item_t c;
        wait_slot();
        pick = $urandom_range(0, 99);
        if (member_count > GROW_CAP)
            pick = $urandom_range(0, 1) ? 0 : 20;
        v   = $urandom;
        idx = IDX_W'($urandom);
        if (pick < 6)
            act = ACT_CLEAR;
        else if (pick < 18)
        begin
            act = ACT_SEED;
            // copies of members give the equal-member case
            if (member_count > 0 && $urandom_range(0, 2) == 0)
                v = any_member();
        end
        else if (pick < 32)
        begin
            act = ACT_REMOVE;
            if (member_count > 0 && $urandom_range(0, 3) != 0)
                idx = IDX_W'($urandom_range(0, member_count - 1));
        end
        else
        begin
            act  = ACT_TRY;
            kind = $urandom_range(0, 6);
            if (kind == 1)
                v = v & 32'h0000_001F;
            else if (kind >= 2 && member_count > 0)
            begin
                p = any_member();
                r = any_member();
                case (kind)
                    2: v = p;
                    // agrees with p or r at every bit: right angle at itself
                    3: v = (p & v) | (r & ~v);
                    // differs from p only where r agrees with p
                    4: v = p ^ (v & ~(r ^ p));
                    5: v = p ^ (32'h1 << $urandom_range(0, 31));
                    default: v = p ^ (v & 32'h0000_00FF);
                endcase
            end
        end
        c.action = act;
        c.vector = v;
        c.index  = idx;
        pending_cmds.push_back(c);
    endtask

    initial
    begin
        int n;
        int ph;
        logic [TGT_W-1:0] phase_target [5];

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty set, duplicate, right angle at the candidate
        send_cmd(ACT_REMOVE, 32'hFFFF_FFFF, 9'h1FF);
        send_cmd(ACT_TRY,    32'h0000_0000, 9'h1FF);
        send_cmd(ACT_TRY,    32'h0000_0000, 9'h000);
        send_cmd(ACT_TRY,    32'hFFFF_FFFF, 9'h000);
        send_cmd(ACT_TRY,    32'h0000_FFFF, 9'h0AA);
        // equal members from an unchecked seed block every try-add
        send_cmd(ACT_SEED,   32'h0000_0000, 9'h155);
        send_cmd(ACT_TRY,    32'h1234_5678, 9'h000);
        // remove the last entry, then one that pulls the last into its slot
        send_cmd(ACT_REMOVE, 32'h0000_0000, 9'd2);
        send_cmd(ACT_REMOVE, 32'h0000_0000, 9'd0);
        send_cmd(ACT_REMOVE, 32'h0000_0000, 9'd1);
        send_cmd(ACT_CLEAR,  32'hFFFF_FFFF, 9'h1FF);
        send_cmd(ACT_TRY,    32'hA5A5_A5A5, 9'h000);
        send_cmd(ACT_TRY,    32'h5A5A_5A5A, 9'h000);
        send_cmd(ACT_TRY,    32'hFFFF_0000, 9'h000);

        // target size at its extremes and just above the count
        write_target(10'd0);
        send_cmd(ACT_TRY,    32'h0000_0001, 9'h000);
        write_target(10'd2);
        send_cmd(ACT_CLEAR,  32'h0000_0000, 9'h000);
        send_cmd(ACT_TRY,    32'h0000_0001, 9'h000);
        send_cmd(ACT_TRY,    32'h0000_0002, 9'h000);
        send_cmd(ACT_TRY,    32'h0000_0004, 9'h000);
        write_target(10'd512);

        // random phases, each under its own target size
        phase_target[0] = 10'd12;
        phase_target[1] = 10'd1;
        phase_target[2] = 10'd512;
        phase_target[3] = TGT_W'($urandom_range(2, GROW_CAP));
        phase_target[4] = 10'd30;
        for (ph = 0; ph < 5; ph++)
        begin
            write_target(phase_target[ph]);
            for (n = 0; n < 16; n++)
                send_random_cmd();
        end

        while (pending_cmds.size() != 0 || expected_outcomes.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (!mismatch_seen)
            $display("[hypercube_acute_set_builder_unit] OK");
        else
            $display("[hypercube_acute_set_builder_unit] ERROR");
        $finish;
    end

endmodule
